FILE: rtl/assert_macros.svh
// Assertion macros shared by the distance accumulator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that condition c holds in the same cycle whenever a holds.
`define ASSERT_IMPLIES(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// Checks that condition c holds in the cycle after a holds.
`define ASSERT_NEXT(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

FILE: rtl/eda_pkg.sv
// Shared constants and controller-to-datapath command type for the distance accumulator.
package eda_pkg;

   // Width of the element ports.
   localparam int DATA_BITS = 16;
   // Width of the running sum of squares (Q26.16).
   localparam int ACC_BITS = 42;
   // Width of the distance result (Q13.8).
   localparam int DIST_BITS = 21;
   // One root bit is resolved per step.
   localparam int ROOT_STEPS = DIST_BITS;
   // Partial remainder of the square root; it never reaches 2^22.
   localparam int REM_BITS = DIST_BITS + 3;
   localparam int STEP_CNT_BITS = $clog2(ROOT_STEPS);

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_sq;    // Register the square of the accepted pair.
      logic acc_add;    // Add the registered square to the running sum.
      logic acc_final;  // Add the last square, start the root, clear the sum.
      logic root_step;  // Resolve one bit of the square root.
   } cmd_type;

endpackage

FILE: rtl/eda_ctrl.sv
// Controller: input staging, square-root sequencing and result handshake.
`include "assert_macros.svh"

module eda_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_last_elem,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output eda_pkg::cmd_type   cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CALC = 3'b010,
      ST_SEND = 3'b100
   } state_type;

   state_type                              state_ff, state_in;
   logic [eda_pkg::STEP_CNT_BITS-1:0]      cnt_ff, cnt_in;
   logic                                   sq_vld_ff, sq_vld_in;
   logic                                   sq_last_ff, sq_last_in;
   logic                                   advance;
   logic                                   accept;

   // The square stage moves on unless it holds a last pair and the root unit is busy.
   assign advance   = sq_vld_ff && (!sq_last_ff || (state_ff == ST_IDLE));
   assign req_ready = !sq_vld_ff || advance;
   assign accept    = req_valid && req_ready;

   // Square stage occupancy.
   always_comb begin
      sq_vld_in  = sq_vld_ff;
      sq_last_in = sq_last_ff;
      if (accept) begin
         sq_vld_in  = 1'b1;
         sq_last_in = req_last_elem;
      end else if (advance) begin
         sq_vld_in  = 1'b0;
      end
   end

   // Commands to the datapath.
   always_comb begin
      cmd.load_sq   = accept;
      cmd.acc_add   = advance && !sq_last_ff;
      cmd.acc_final = advance && sq_last_ff;
      cmd.root_step = (state_ff == ST_CALC);
   end

   assign rsp_valid = (state_ff == ST_SEND);

   // Square-root sequencer and result handshake.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.acc_final) begin
               state_in = ST_CALC;
               cnt_in   = '0;
            end
         end
         ST_CALC: begin
            cnt_in = cnt_ff + eda_pkg::STEP_CNT_BITS'(1);
            if (cnt_ff == eda_pkg::STEP_CNT_BITS'(eda_pkg::ROOT_STEPS - 1)) begin
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cnt_ff     <= '0;
         sq_vld_ff  <= 1'b0;
         sq_last_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         sq_vld_ff  <= sq_vld_in;
         sq_last_ff <= sq_last_in;
      end
   end

   // A last pair waiting on a busy root unit must block new transactions.
   `ASSERT_IMPLIES(a_last_stalls, clock, reset,
      sq_vld_ff && sq_last_ff && (state_ff != ST_IDLE), !req_ready,
      "last pair passed a busy root unit")
   // Starting a root always begins a fresh step count.
   `ASSERT_NEXT(a_root_start, clock, reset, cmd.acc_final,
      (state_ff == ST_CALC) && (cnt_ff == '0), "root did not start cleanly")
   // The step counter stays within the number of root bits.
   `ASSERT_IMPLIES(a_cnt_range, clock, reset, state_ff == ST_CALC,
      cnt_ff < eda_pkg::STEP_CNT_BITS'(eda_pkg::ROOT_STEPS), "root step count out of range")

endmodule

FILE: rtl/eda_datapath.sv
// Datapath: squared difference, saturating accumulator and bit-serial square root.
`include "assert_macros.svh"

module eda_datapath #(
   parameter int ELEM_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  eda_pkg::cmd_type                  cmd,
   input  logic signed [eda_pkg::DATA_BITS-1:0] req_a_elem,
   input  logic signed [eda_pkg::DATA_BITS-1:0] req_b_elem,
   output logic [eda_pkg::DIST_BITS-1:0]     rsp_distance,
   output logic                              rsp_overflow
);

   localparam int RAW_W = (ELEM_BITS > eda_pkg::DATA_BITS) ? ELEM_BITS : eda_pkg::DATA_BITS;
   localparam int SQ_W  = 2 * ELEM_BITS;
   localparam int SUM_W = ((SQ_W > eda_pkg::ACC_BITS) ? SQ_W : eda_pkg::ACC_BITS) + 1;
   localparam int ACC_W = eda_pkg::ACC_BITS;
   localparam int REM_W = eda_pkg::REM_BITS;
   localparam int DST_W = eda_pkg::DIST_BITS;

   logic [RAW_W-1:0]          a_wide, b_wide;
   logic signed [ELEM_BITS:0] a_val, b_val, diff;
   logic [ELEM_BITS:0]        abs_full;
   logic [ELEM_BITS-1:0]      mag;
   logic [SQ_W-1:0]           sq_in;
   logic [SQ_W-1:0]           sq_ff;

   logic [SUM_W-1:0]          sum_w;
   logic                      sat_now;
   logic [ACC_W-1:0]          sum_sat;
   logic [ACC_W-1:0]          acc_ff, acc_in;
   logic                      sat_ff, sat_in;

   logic [ACC_W-1:0]          x_ff;
   logic [REM_W-1:0]          rem_ff;
   logic [DST_W-1:0]          q_ff;
   logic                      ovf_ff;
   logic [REM_W-1:0]          rem_sh, trial;

   // Take the low ELEM_BITS of each element as two's complement.
   assign a_wide = RAW_W'($unsigned(req_a_elem));
   assign b_wide = RAW_W'($unsigned(req_b_elem));
   assign a_val  = $signed({a_wide[ELEM_BITS-1], a_wide[ELEM_BITS-1:0]});
   assign b_val  = $signed({b_wide[ELEM_BITS-1], b_wide[ELEM_BITS-1:0]});

   // Magnitude of the difference fits in ELEM_BITS, then one multiply.
   assign diff     = a_val - b_val;
   assign abs_full = diff[ELEM_BITS] ? $unsigned(-diff) : $unsigned(diff);
   assign mag      = abs_full[ELEM_BITS-1:0];
   assign sq_in    = SQ_W'(mag) * SQ_W'(mag);

   always_ff @(posedge clock) begin
      if (cmd.load_sq) begin
         sq_ff <= sq_in;
      end
   end

   // Saturating add: any carry past the accumulator width pins it at all ones.
   assign sum_w   = SUM_W'(acc_ff) + SUM_W'(sq_ff);
   assign sat_now = |sum_w[SUM_W-1:ACC_W];
   assign sum_sat = sat_now ? {ACC_W{1'b1}} : sum_w[ACC_W-1:0];

   always_comb begin
      acc_in = acc_ff;
      sat_in = sat_ff;
      if (cmd.acc_final) begin
         acc_in = '0;
         sat_in = 1'b0;
      end else if (cmd.acc_add) begin
         acc_in = sum_sat;
         sat_in = sat_ff | sat_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         sat_ff <= 1'b0;
      end else begin
         acc_ff <= acc_in;
         sat_ff <= sat_in;
      end
   end

   // Restoring square root: bring down two radicand bits and try the next root bit.
   assign rem_sh = {rem_ff[REM_W-3:0], x_ff[ACC_W-1 -: 2]};
   assign trial  = REM_W'({q_ff, 2'b01});

   always_ff @(posedge clock) begin
      if (cmd.acc_final) begin
         x_ff   <= sum_sat;
         rem_ff <= '0;
         q_ff   <= '0;
         ovf_ff <= sat_ff | sat_now;
      end else if (cmd.root_step) begin
         x_ff <= {x_ff[ACC_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_ff <= rem_sh - trial;
            q_ff   <= {q_ff[DST_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            q_ff   <= {q_ff[DST_W-2:0], 1'b0};
         end
      end
   end

   assign rsp_distance = q_ff;
   assign rsp_overflow = ovf_ff;

   // A saturated sum is always pinned at its maximum.
   `ASSERT_IMPLIES(a_sat_pinned, clock, reset, sat_ff, acc_ff == {ACC_W{1'b1}},
      "saturation flag set without a pinned sum")
   // Closing a vector leaves a clean accumulator for the next one.
   `ASSERT_NEXT(a_acc_cleared, clock, reset, cmd.acc_final, (acc_ff == '0) && !sat_ff,
      "accumulator not cleared after last pair")

endmodule

FILE: rtl/euclidean_distance_accumulator.sv
// Top level of the Euclidean distance accumulator.
// Each transaction on the req_ channel carries one element pair of two Q8.8 vectors;
// the squared difference goes into a 42-bit Q26.16 sum that saturates at all ones
// and sets the overflow flag. On the pair marked last, the block returns one rsp_
// transaction with the floor square root of the sum as a Q13.8 distance and clears
// the sum. Pairs are taken one per cycle: a pair is squared in one register stage and
// added in the next. The square root is computed bit-serially, one bit per cycle,
// after the last pair is added, and overlaps the next vector. The last pair of a
// vector waits in the square stage while the previous root is still being computed
// or its result has not been taken, so vectors of about 23 pairs or more stream
// without a stall as long as results are taken promptly. A result is offered on
// rsp_ once every root bit of its vector has been resolved.
module euclidean_distance_accumulator #(
   parameter int ELEM_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [eda_pkg::DATA_BITS-1:0] req_a_elem,
   input  logic signed [eda_pkg::DATA_BITS-1:0] req_b_elem,
   input  logic                                 req_last_elem,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [eda_pkg::DIST_BITS-1:0]        rsp_distance,
   output logic                                 rsp_overflow
);

   eda_pkg::cmd_type cmd;

   // Sequencing and handshakes.
   eda_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_elem (req_last_elem),
      .req_ready     (req_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .cmd           (cmd)
   );

   // Arithmetic.
   eda_datapath #(
      .ELEM_BITS (ELEM_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .req_a_elem   (req_a_elem),
      .req_b_elem   (req_b_elem),
      .rsp_distance (rsp_distance),
      .rsp_overflow (rsp_overflow)
   );

endmodule
